/* hw/rtl/rnaf_pkg.sv */
package rnaf_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam int Q16_ONE = 65536;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 11;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER_TENTHS = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_OUTER_TENTHS = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    localparam int TRIG_W = 18;
    localparam int QUOT_W = 18;
    localparam int SUM_W = 28;
    localparam int RGB_W = 24;

    typedef logic signed [TRIG_W-1:0] trig_val_t;

    typedef struct packed {
        trig_val_t cos_val;
        trig_val_t sin_val;
    } trig_t;

    typedef struct packed {
        logic       start;
        logic [9:0] three_r;
        logic [9:0] total;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    typedef longint atan_tab_t [CORDIC_STEPS];

    localparam atan_tab_t ATAN_TURNS = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
        64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
        64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
        64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
        64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
        64'h00000014, 64'h0000000A, 64'h00000005
    };

    // Rounds a Q30 value to Q16 and clamps it to plus or minus one.
    function automatic trig_val_t to_q16(input longint v);
        longint r;
        r = (v + 64'sd8192) >>> 14;
        if (r > Q16_ONE) r = Q16_ONE;
        if (r < -Q16_ONE) r = -Q16_ONE;
        return TRIG_W'(r);
    endfunction

    // Cosine and sine of an angle given in units of 2^-32 turn.
    function automatic trig_t angle_trig(input logic [63:0] ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        trig_val_t c;
        trig_val_t s;
        trig_t res;
        logic [1:0] quad;
        quad = ang[31:30];
        z = longint'({34'd0, ang[29:0]});
        x = CORDIC_GAIN_Q30;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[i];
            end
            else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[i];
            end
        end
        c = to_q16(x);
        s = to_q16(y);
        case (quad)
            2'd0:    begin res.cos_val = c;  res.sin_val = s;  end
            2'd1:    begin res.cos_val = -s; res.sin_val = c;  end
            2'd2:    begin res.cos_val = -c; res.sin_val = -s; end
            default: begin res.cos_val = s;  res.sin_val = -c; end
        endcase
        return res;
    endfunction

endpackage

/* hw/rtl/rnaf_if.sv */
interface rnaf_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        frame_end;
    logic signed [39:0] preset_value;

    modport source (output valid, kind, red, green, blue, frame_end, preset_value,
                    input ready);
    modport sink (input valid, kind, red, green, blue, frame_end, preset_value,
                  output ready);
endinterface

interface rnaf_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  needle_bin;
    logic signed [8:0]  step_bins;
    logic signed [39:0] reading;
    logic [27:0] peak_score;

    modport source (output valid, needle_bin, step_bins, reading, peak_score,
                    input ready);
    modport sink (input valid, needle_bin, step_bins, reading, peak_score,
                  output ready);
endinterface

interface rnaf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/rnaf_ram.sv */
module rnaf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 524288
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* hw/rtl/rnaf_angle_rom.sv */
module rnaf_angle_rom #(
    parameter int ANGLE_BINS = 256
) (
    input  logic                          clk,
    input  logic [$clog2(ANGLE_BINS)-1:0] addr,
    output rnaf_pkg::trig_t               data
);

    rnaf_pkg::trig_t rom [ANGLE_BINS];

    // Each entry is worked out at elaboration from the bin's angle.
    for (genvar t = 0; t < ANGLE_BINS; t++) begin : g_entry
        localparam logic [63:0] ANG = (64'(t) << 32) / ANGLE_BINS;
        localparam rnaf_pkg::trig_t ENTRY = rnaf_pkg::angle_trig(ANG);
        assign rom[t] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        data <= rom[addr];
    end

endmodule

/* hw/rtl/rnaf_ratio_div.sv */
module rnaf_ratio_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rnaf_pkg::div_req_t   req,
    output rnaf_pkg::div_rsp_t   rsp
);

    // Computes floor(three_r * 65536 / total). The integer part is at most
    // three and is found at start; the sixteen fraction bits follow one a cycle.
    logic       busy_reg, busy_next;
    logic [4:0] count_reg, count_next;
    logic [9:0] total_reg, total_next;
    logic [9:0] rem_reg, rem_next;
    logic [rnaf_pkg::QUOT_W-1:0] quot_reg, quot_next;

    logic [11:0] one_s, two_s, three_s, tr;
    logic [10:0] rem_shift;
    logic [1:0]  q_hi;
    logic [11:0] sub_hi;

    always_comb
    begin
        tr      = {2'b00, req.three_r};
        one_s   = {2'b00, req.total};
        two_s   = {1'b0, req.total, 1'b0};
        three_s = one_s + two_s;
        if (tr >= three_s)
        begin
            q_hi = 2'd3;
            sub_hi = three_s;
        end
        else if (tr >= two_s)
        begin
            q_hi = 2'd2;
            sub_hi = two_s;
        end
        else if (tr >= one_s)
        begin
            q_hi = 2'd1;
            sub_hi = one_s;
        end
        else
        begin
            q_hi = 2'd0;
            sub_hi = 12'd0;
        end

        rem_shift  = {rem_reg, 1'b0};
        busy_next  = busy_reg;
        count_next = count_reg;
        total_next = total_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;

        if (req.start)
        begin
            busy_next  = 1'b1;
            count_next = 5'd0;
            total_next = req.total;
            rem_next   = 10'(tr - sub_hi);
            quot_next  = {q_hi, 16'd0};
        end
        else if (busy_reg)
        begin
            // The count reaches sixteen once every fraction bit is in place; the
            // quotient is then presented for one cycle.
            if (count_reg == 5'd16)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                if (rem_shift >= {1'b0, total_reg})
                begin
                    rem_next = 10'(rem_shift - {1'b0, total_reg});
                    quot_next[5'd15 - 4'(count_reg)] = 1'b1;
                end
                else
                begin
                    rem_next = rem_shift[9:0];
                end
                count_next = count_reg + 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= 5'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        total_reg <= total_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
    end

    assign rsp.done     = busy_reg && (count_reg == 5'd16);
    assign rsp.quotient = quot_reg;

endmodule

/* hw/rtl/radial_needle_angle_finder.sv */
// Channel  Direction  Payload                                          Transaction
// item     in         kind, red, green, blue, frame_end, preset_value  valid && ready
// result   out        needle_bin, step_bins, reading, peak_score       valid && ready
// cfg      in         index, data                                      valid && ready
//
// Pixel and preset items are taken on valid && ready; item.ready is high only while no search runs.
// A frame end with nonzero radius starts a search of ANGLE_BINS rays. Each ray runs
// BIN_START, then per pixel walked STEP, MUL, ADDR and READ, plus DIV on the serial ratio
// divider for a non-black pixel, and ends in BIN_END from STEP or, off the frame, from MUL;
// the divider and the single frame memory read port set the speed. FINISH hands the result
// to the output register. A finished result waits there while new items are accepted.
// Reset is asynchronous and active low; the frame memory is not cleared.
module radial_needle_angle_finder #(
    parameter int ANGLE_BINS = 256,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  clk,
    input  logic                  rst_n,
    rnaf_item_if.sink             item,
    rnaf_result_if.source         result,
    rnaf_cfg_if.sink              cfg
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int BIN_W  = $clog2(ANGLE_BINS);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int XW     = $clog2(MAX_WIDTH);
    localparam int YW     = $clog2(MAX_HEIGHT);
    localparam int SUM_W  = rnaf_pkg::SUM_W;

    // Search sequencer states.
    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_BIN_START = 4'd1;
    localparam logic [3:0] ST_STEP      = 4'd2;
    localparam logic [3:0] ST_MUL       = 4'd3;
    localparam logic [3:0] ST_ADDR      = 4'd4;
    localparam logic [3:0] ST_READ      = 4'd5;
    localparam logic [3:0] ST_DIV       = 4'd6;
    localparam logic [3:0] ST_BIN_END   = 4'd7;
    localparam logic [3:0] ST_FINISH    = 4'd8;

    // Configuration registers.
    logic [9:0]  center_x_reg, center_y_reg, radius_reg;
    logic [3:0]  inner_reg, outer_reg;
    logic [10:0] width_reg;
    logic [9:0]  height_reg;

    logic [3:0]  state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BIN_W-1:0] best_bin_reg, best_bin_next;
    logic [BIN_W-1:0] prev_bin_reg, prev_bin_next;
    logic [SUM_W-1:0] best_reg, best_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic signed [39:0] reading_reg, reading_next;
    logic [9:0]  d_reg, d_next;
    logic [9:0]  dstart_reg, dstart_next;
    logic [13:0] limit_reg, limit_next;
    logic [WW-1:0] w_reg, w_next;
    logic [HW-1:0] h_reg, h_next;
    logic signed [28:0] prod_x_reg, prod_x_next, prod_y_reg, prod_y_next;
    logic [XW-1:0] px_reg, px_next;
    logic [AW-1:0] pyw_reg, pyw_next;

    logic        res_valid_reg, res_valid_next;
    logic [7:0]  res_bin_reg, res_bin_next;
    logic signed [8:0]  res_step_reg, res_step_next;
    logic signed [39:0] res_reading_reg, res_reading_next;
    logic [27:0] res_score_reg, res_score_next;

    logic        item_acc;
    logic        mem_we, mem_re;
    logic [AW-1:0] mem_raddr;
    logic [rnaf_pkg::RGB_W-1:0] mem_rdata;
    rnaf_pkg::trig_t trig;
    rnaf_pkg::div_req_t div_req;
    rnaf_pkg::div_rsp_t div_rsp;

    // Working values of the sequencer.
    logic [3:0]  in_sat, out_sat;
    logic [13:0] in_r;
    logic [29:0] dstart_prod;
    logic [13:0] d_times_ten;
    logic [9:0]  pix_total;
    int          px_i, py_i, step_i, diff_i, d2_i, d3_i, a1_i, a2_i, a3_i;
    logic [28:0] mag_x, mag_y;
    logic [YW+WW-1:0] pyw_full;
    logic signed [40:0] sat_sum;

    assign item_acc   = item.valid && item.ready;
    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign mem_we = item_acc && !item.kind;

    rnaf_ram #(
        .WIDTH (rnaf_pkg::RGB_W),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (wp_reg),
        .wr_data ({item.red, item.green, item.blue}),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    rnaf_angle_rom #(
        .ANGLE_BINS (ANGLE_BINS)
    ) u_angle_rom (
        .clk  (clk),
        .addr (bin_reg),
        .data (trig)
    );

    rnaf_ratio_div u_ratio_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= 10'd0;
            center_y_reg <= 10'd0;
            radius_reg   <= 10'd0;
            inner_reg    <= 4'd0;
            outer_reg    <= 4'd10;
            width_reg    <= 11'd640;
            height_reg   <= 10'd360;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                rnaf_pkg::REG_CENTER_X:     center_x_reg <= cfg.data[9:0];
                rnaf_pkg::REG_CENTER_Y:     center_y_reg <= cfg.data[9:0];
                rnaf_pkg::REG_RADIUS:       radius_reg   <= cfg.data[9:0];
                rnaf_pkg::REG_INNER_TENTHS: inner_reg    <= cfg.data[3:0];
                rnaf_pkg::REG_OUTER_TENTHS: outer_reg    <= cfg.data[3:0];
                rnaf_pkg::REG_FRAME_WIDTH:  width_reg    <= cfg.data;
                rnaf_pkg::REG_FRAME_HEIGHT: height_reg   <= cfg.data[9:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        wp_next       = wp_reg;
        bin_next      = bin_reg;
        best_bin_next = best_bin_reg;
        prev_bin_next = prev_bin_reg;
        best_next     = best_reg;
        sum_next      = sum_reg;
        reading_next  = reading_reg;
        d_next        = d_reg;
        dstart_next   = dstart_reg;
        limit_next    = limit_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        prod_x_next   = prod_x_reg;
        prod_y_next   = prod_y_reg;
        px_next       = px_reg;
        pyw_next      = pyw_reg;
        res_valid_next   = res_valid_reg;
        res_bin_next     = res_bin_reg;
        res_step_next    = res_step_reg;
        res_reading_next = res_reading_reg;
        res_score_next   = res_score_reg;
        mem_re    = 1'b0;
        mem_raddr = AW'(pyw_reg + AW'(px_reg));
        div_req.start   = 1'b0;
        div_req.three_r = 10'(2'd3 * mem_rdata[23:16]);
        div_req.total   = 10'(mem_rdata[23:16]) + 10'(mem_rdata[15:8])
                          + 10'(mem_rdata[7:0]);
        pix_total = div_req.total;

        // Scan limits in tenths of the radius; divide by ten via a reciprocal.
        in_sat  = (inner_reg > 4'd10) ? 4'd10 : inner_reg;
        out_sat = (outer_reg > 4'd10) ? 4'd10 : outer_reg;
        in_r    = 14'(in_sat * radius_reg);
        dstart_prod = 30'(in_r * 16'd52429);
        d_times_ten = 14'({d_reg, 3'b000}) + 14'({d_reg, 1'b0});

        // Ray coordinates, truncated toward zero.
        mag_x = prod_x_reg[28] ? 29'(-prod_x_reg) : prod_x_reg;
        mag_y = prod_y_reg[28] ? 29'(-prod_y_reg) : prod_y_reg;
        px_i = int'(center_x_reg) + (prod_x_reg[28] ? -int'(mag_x[26:16])
                                                    : int'(mag_x[26:16]));
        py_i = int'(center_y_reg) + (prod_y_reg[28] ? -int'(mag_y[26:16])
                                                    : int'(mag_y[26:16]));
        pyw_full = YW'(py_i) * w_reg;

        // Wrapped bin step; ties prefer the plain difference, then the upward wrap.
        diff_i = int'(best_bin_reg) - int'(prev_bin_reg);
        d2_i   = diff_i + ANGLE_BINS;
        d3_i   = diff_i - ANGLE_BINS;
        a1_i   = (diff_i < 0) ? -diff_i : diff_i;
        a2_i   = (d2_i < 0) ? -d2_i : d2_i;
        a3_i   = (d3_i < 0) ? -d3_i : d3_i;
        if (a1_i <= a2_i && a1_i <= a3_i)
        begin
            step_i = diff_i;
        end
        else if (a2_i <= a3_i)
        begin
            step_i = d2_i;
        end
        else
        begin
            step_i = d3_i;
        end
        sat_sum = 41'(reading_reg) + 41'(step_i);

        if (result.ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    if (item.kind)
                    begin
                        reading_next = item.preset_value;
                    end
                    else if (item.frame_end)
                    begin
                        wp_next = '0;
                        if (radius_reg != 10'd0)
                        begin
                            dstart_next = dstart_prod[28:19];
                            limit_next  = 14'(out_sat * radius_reg);
                            w_next = (32'(width_reg) > MAX_WIDTH) ? WW'(MAX_WIDTH)
                                                                  : WW'(width_reg);
                            h_next = (32'(height_reg) > MAX_HEIGHT) ? HW'(MAX_HEIGHT)
                                                                    : HW'(height_reg);
                            bin_next  = '0;
                            best_next = '0;
                            best_bin_next = '0;
                            state_next = ST_BIN_START;
                        end
                    end
                    else
                    begin
                        wp_next = (32'(wp_reg) == DEPTH - 1) ? '0 : AW'(wp_reg + 1'b1);
                    end
                end
            end
            ST_BIN_START:
            begin
                d_next   = dstart_reg;
                sum_next = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (d_times_ten >= limit_reg)
                begin
                    state_next = ST_BIN_END;
                end
                else
                begin
                    prod_x_next = $signed({1'b0, d_reg}) * trig.cos_val;
                    prod_y_next = $signed({1'b0, d_reg}) * trig.sin_val;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (px_i < 0 || py_i < 0 || px_i >= int'(w_reg) || py_i >= int'(h_reg))
                begin
                    state_next = ST_BIN_END;
                end
                else
                begin
                    px_next  = XW'(px_i);
                    pyw_next = AW'(pyw_full);
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                mem_re = 1'b1;
                state_next = ST_READ;
            end
            ST_READ:
            begin
                if (pix_total == 10'd0)
                begin
                    d_next = d_reg + 10'd1;
                    state_next = ST_STEP;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    sum_next = sum_reg + SUM_W'(div_rsp.quotient);
                    d_next = d_reg + 10'd1;
                    state_next = ST_STEP;
                end
            end
            ST_BIN_END:
            begin
                if (bin_reg == '0 || sum_reg > best_reg)
                begin
                    best_next = sum_reg;
                    best_bin_next = bin_reg;
                end
                if (32'(bin_reg) == ANGLE_BINS - 1)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    bin_next = bin_reg + 1'b1;
                    state_next = ST_BIN_START;
                end
            end
            ST_FINISH:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next = 1'b1;
                    res_bin_next   = 8'(best_bin_reg);
                    res_step_next  = 9'(step_i);
                    res_score_next = best_reg;
                    if (sat_sum[40] != sat_sum[39])
                    begin
                        reading_next = sat_sum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}};
                    end
                    else
                    begin
                        reading_next = sat_sum[39:0];
                    end
                    res_reading_next = reading_next;
                    prev_bin_next = best_bin_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            prev_bin_reg  <= '0;
            reading_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            prev_bin_reg  <= prev_bin_next;
            reading_reg   <= reading_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        best_bin_reg <= best_bin_next;
        best_reg     <= best_next;
        sum_reg      <= sum_next;
        d_reg        <= d_next;
        dstart_reg   <= dstart_next;
        limit_reg    <= limit_next;
        w_reg        <= w_next;
        h_reg        <= h_next;
        prod_x_reg   <= prod_x_next;
        prod_y_reg   <= prod_y_next;
        px_reg       <= px_next;
        pyw_reg      <= pyw_next;
        res_bin_reg     <= res_bin_next;
        res_step_reg    <= res_step_next;
        res_reading_reg <= res_reading_next;
        res_score_reg   <= res_score_next;
    end

    assign result.valid      = res_valid_reg;
    assign result.needle_bin = res_bin_reg;
    assign result.step_bins  = res_step_reg;
    assign result.reading    = res_reading_reg;
    assign result.peak_score = res_score_reg;

`ifndef SYNTHESIS
    a_wp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wp_reg) < DEPTH)
        else $error("write pointer beyond frame store");

    a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("frame store written during search");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (div_req.total != 10'd0))
        else $error("divider started on a black pixel");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && !item.kind && item.frame_end && radius_reg != 10'd0)
        |=> (state_reg == ST_BIN_START && bin_reg == '0))
        else $error("frame end did not start the search");
`endif

endmodule

/* verif/radial_needle_angle_finder_tb.sv */
// Testbench for the radial needle angle finder.
// A scoreboard class keeps its own frame store, angle table, configuration and reading,
// predicts one result per searched frame and compares every result transaction with the
// oldest prediction. Plain tasks drive the item and configuration channels, and a
// separate process drains the result channel with random stalls.
module radial_needle_angle_finder_tb;

    localparam int NBINS = 256;
    localparam int WMAX = 1024;
    localparam int HMAX = 512;
    localparam int DEPTH = WMAX * HMAX;
    localparam longint RD_MAX = 64'sd549755813887;
    localparam longint RD_MIN = -64'sd549755813888;

    typedef struct {
        logic [7:0]  needle_bin;
        logic [8:0]  step_bins;
        logic [39:0] reading;
        logic [27:0] peak_score;
    } needle_result_t;

    // The scoreboard predicts needle results from accepted items and checks them.
    class needle_scoreboard;
        longint cx, cy, rad, inner_t, outer_t, fw, fh;
        logic [23:0] pixels [DEPTH];
        int unsigned wr_ptr;
        longint last_bin;
        longint reading_acc;
        longint cos_tab [NBINS];
        longint sin_tab [NBINS];
        needle_result_t pending_q [$];
        int errors;

        function new();
            cx = 0; cy = 0; rad = 0; inner_t = 0; outer_t = 10; fw = 640; fh = 360;
            wr_ptr = 0; last_bin = 0; reading_acc = 0; errors = 0;
            build_angles();
        endfunction

        function longint round_q16(longint v);
            longint r;
            r = (v + 8192) >>> 14;
            if (r > rnaf_pkg::Q16_ONE) r = rnaf_pkg::Q16_ONE;
            if (r < -rnaf_pkg::Q16_ONE) r = -rnaf_pkg::Q16_ONE;
            return r;
        endfunction

        // Fixed-point cosine and sine of every bin, CORDIC on the low 30 angle bits.
        function void build_angles();
            longint x, y, z, dx, dy, c, s;
            logic [63:0] ang;
            logic [1:0] quad;
            for (int t = 0; t < NBINS; t++)
            begin
                ang = (64'(t) << 32) / NBINS;
                quad = ang[31:30];
                z = longint'({34'd0, ang[29:0]});
                x = rnaf_pkg::CORDIC_GAIN_Q30;
                y = 0;
                for (int i = 0; i < rnaf_pkg::CORDIC_STEPS; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0)
                    begin
                        x -= dx; y += dy; z -= rnaf_pkg::ATAN_TURNS[i];
                    end
                    else
                    begin
                        x += dx; y -= dy; z += rnaf_pkg::ATAN_TURNS[i];
                    end
                end
                c = round_q16(x);
                s = round_q16(y);
                case (quad)
                    2'd0:    begin cos_tab[t] = c;  sin_tab[t] = s;  end
                    2'd1:    begin cos_tab[t] = -s; sin_tab[t] = c;  end
                    2'd2:    begin cos_tab[t] = -c; sin_tab[t] = -s; end
                    default: begin cos_tab[t] = s;  sin_tab[t] = -c; end
                endcase
            end
        endfunction

        function void set_reg(logic [rnaf_pkg::CFG_INDEX_W-1:0] idx,
                              logic [rnaf_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                rnaf_pkg::REG_CENTER_X:     cx = val[9:0];
                rnaf_pkg::REG_CENTER_Y:     cy = val[9:0];
                rnaf_pkg::REG_RADIUS:       rad = val[9:0];
                rnaf_pkg::REG_INNER_TENTHS: inner_t = val[3:0];
                rnaf_pkg::REG_OUTER_TENTHS: outer_t = val[3:0];
                rnaf_pkg::REG_FRAME_WIDTH:  fw = val[10:0];
                rnaf_pkg::REG_FRAME_HEIGHT: fh = val[9:0];
                default: ;
            endcase
        endfunction

        function longint toward_zero(longint p);
            return (p >= 0) ? (p >>> 16) : -((-p) >>> 16);
        endfunction

        // Redness sum along one ray; the walk ends at the first pixel off the frame.
        function longint ray_redness(int t, longint w, longint h);
            longint it, ot, d, lim, px, py, sum, r, g, b;
            logic [23:0] pix;
            it = (inner_t > 10) ? 10 : inner_t;
            ot = (outer_t > 10) ? 10 : outer_t;
            d = (it * rad) / 10;
            lim = ot * rad;
            sum = 0;
            for (; d * 10 < lim; d++)
            begin
                px = cx + toward_zero(d * cos_tab[t]);
                py = cy + toward_zero(d * sin_tab[t]);
                if (px < 0 || py < 0 || px >= w || py >= h)
                    break;
                pix = pixels[py * w + px];
                r = pix[23:16]; g = pix[15:8]; b = pix[7:0];
                if (r + g + b != 0)
                    sum += (3 * r * rnaf_pkg::Q16_ONE) / (r + g + b);
            end
            return sum;
        endfunction

        function void note_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic fend, logic signed [39:0] preset);
            longint w, h, best, s, diff, d2, d3, a1, a2, a3, stp;
            int best_bin;
            needle_result_t res;
            if (kind)
            begin
                reading_acc = longint'(preset);
                return;
            end
            pixels[wr_ptr] = {r, g, b};
            wr_ptr = (wr_ptr + 1 >= DEPTH) ? 0 : wr_ptr + 1;
            if (!fend)
                return;
            wr_ptr = 0;
            if (rad == 0)
                return;
            w = (fw > WMAX) ? WMAX : fw;
            h = (fh > HMAX) ? HMAX : fh;
            best = 0;
            best_bin = 0;
            for (int t = 0; t < NBINS; t++)
            begin
                s = ray_redness(t, w, h);
                if (t == 0 || s > best)
                begin
                    best = s;
                    best_bin = t;
                end
            end
            diff = best_bin - last_bin;
            d2 = diff + NBINS;
            d3 = diff - NBINS;
            a1 = (diff < 0) ? -diff : diff;
            a2 = (d2 < 0) ? -d2 : d2;
            a3 = (d3 < 0) ? -d3 : d3;
            if (a1 <= a2 && a1 <= a3) stp = diff;
            else if (a2 <= a3) stp = d2;
            else stp = d3;
            last_bin = best_bin;
            if (stp > 0 && reading_acc > RD_MAX - stp) reading_acc = RD_MAX;
            else if (stp < 0 && reading_acc < RD_MIN - stp) reading_acc = RD_MIN;
            else reading_acc += stp;
            if (best > 268435455) best = 268435455;
            res.needle_bin = best_bin[7:0];
            res.step_bins = stp[8:0];
            res.reading = reading_acc[39:0];
            res.peak_score = best[27:0];
            pending_q.push_back(res);
        endfunction

        function void check_result(needle_result_t got);
            needle_result_t want;
            if (pending_q.size() == 0)
            begin
                $error("result transaction with no prediction waiting");
                errors++;
                return;
            end
            want = pending_q.pop_front();
            if (got.needle_bin !== want.needle_bin)
            begin
                $error("needle_bin: expected %0d, actual %0d", want.needle_bin, got.needle_bin);
                errors++;
            end
            if (got.step_bins !== want.step_bins)
            begin
                $error("step_bins: expected %0d, actual %0d",
                       $signed(want.step_bins), $signed(got.step_bins));
                errors++;
            end
            if (got.reading !== want.reading)
            begin
                $error("reading: expected %0d, actual %0d",
                       $signed(want.reading), $signed(got.reading));
                errors++;
            end
            if (got.peak_score !== want.peak_score)
            begin
                $error("peak_score: expected %0d, actual %0d", want.peak_score, got.peak_score);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    rnaf_item_if   item ();
    rnaf_result_if result ();
    rnaf_cfg_if    cfg ();

    radial_needle_angle_finder u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source),
        .cfg    (cfg.sink)
    );

    needle_scoreboard sb;
    int items_sent;
    // When set, the item side sends without gaps; some frames run at full rate.
    bit burst_mode;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // The run is ended here if the block hangs; the bound is far above the slowest run.
    initial
    begin
        #400000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Writes one configuration register; valid is lowered after each transaction so that
    // back-to-back writes never touch valid twice in one step.
    task automatic write_reg(logic [rnaf_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rnaf_pkg::CFG_DATA_W-1:0] val);
        bit ok;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
        begin
            @(negedge clk);
            ok = cfg.ready;
            @(posedge clk);
        end
        while (!ok);
        sb.set_reg(idx, val);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one item. The gap before it is drawn per item, zero in burst mode; ready is sampled at the
    // falling edge so the decision never races the block's own update at the rising edge.
    task automatic send_item(logic kind, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                             logic fend, logic signed [39:0] preset);
        int gap;
        bit ok;
        gap = burst_mode ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            item.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.valid        <= 1'b1;
        item.kind         <= kind;
        item.red          <= r;
        item.green        <= g;
        item.blue         <= b;
        item.frame_end    <= fend;
        item.preset_value <= preset;
        do
        begin
            @(negedge clk);
            ok = item.ready;
            @(posedge clk);
        end
        while (!ok);
        sb.note_item(kind, r, g, b, fend, preset);
        items_sent++;
    endtask

    task automatic send_preset(logic signed [39:0] v);
        send_item(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), v);
    endtask

    function automatic logic signed [39:0] rand_reading();
        logic signed [39:0] v;
        case ($urandom_range(0, 3))
            0: v = 40'sh7FFFFFFFFF - 40'($urandom_range(0, 200));
            1: v = 40'sh8000000000 + 40'($urandom_range(0, 200));
            2: v = 40'($signed($urandom_range(0, 400)) - 200);
            default: v = {8'($urandom), 32'($urandom)};
        endcase
        return v;
    endfunction

    // Sends a whole frame: exactly the number of pixels the saturated frame size covers,
    // so the search only reads entries written in this frame. Zero width or height gets
    // a single pixel. Presets may be mixed in; they do not move the write pointer.
    task automatic send_frame(bit with_presets);
        longint w, h, n;
        logic [7:0] r, g, b;
        w = (sb.fw > WMAX) ? WMAX : sb.fw;
        h = (sb.fh > HMAX) ? HMAX : sb.fh;
        n = (w == 0 || h == 0) ? 1 : w * h;
        for (longint i = 0; i < n; i++)
        begin
            if (with_presets && $urandom_range(0, 15) == 0)
                send_preset(rand_reading());
            case ($urandom_range(0, 5))
                0: begin r = 0; g = 0; b = 0; end
                1: begin r = 8'($urandom_range(128, 255)); g = 0; b = 0; end
                2: begin r = 255; g = 255; b = 255; end
                default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
            endcase
            send_item(1'b0, r, g, b, (i == n - 1), rand_reading());
        end
    endtask

    // Idles the item channel, waits until every predicted result has been drained, then
    // lets the block settle before the configuration changes.
    task automatic wait_drained();
        item.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_geometry(int x, int y, int rr, int it, int ot, int w, int h);
        write_reg(rnaf_pkg::REG_CENTER_X, 11'(x));
        write_reg(rnaf_pkg::REG_CENTER_Y, 11'(y));
        write_reg(rnaf_pkg::REG_RADIUS, 11'(rr));
        write_reg(rnaf_pkg::REG_INNER_TENTHS, 11'(it));
        write_reg(rnaf_pkg::REG_OUTER_TENTHS, 11'(ot));
        write_reg(rnaf_pkg::REG_FRAME_WIDTH, 11'(w));
        write_reg(rnaf_pkg::REG_FRAME_HEIGHT, 11'(h));
    endtask

    // Result side: random stalls, and every result transaction goes to the scoreboard.
    initial
    begin
        needle_result_t got;
        int stall;
        bit seen;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                result.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                seen = result.valid;
                got.needle_bin = result.needle_bin;
                got.step_bins  = result.step_bins;
                got.reading    = result.reading;
                got.peak_score = result.peak_score;
                @(posedge clk);
            end
            while (!seen);
            sb.check_result(got);
        end
    end

    initial
    begin
        int w, h;
        sb = new();
        items_sent = 0;
        burst_mode = 1'b0;
        item.valid = 1'b0;
        item.kind = 1'b0;
        item.red = '0;
        item.green = '0;
        item.blue = '0;
        item.frame_end = 1'b0;
        item.preset_value = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A small frame first, with black, white and pure colors.
        write_geometry(1, 1, 2, 0, 10, 3, 3);
        send_preset(40'sh7FFFFFFFFF);
        send_item(1'b0, 8'd0, 8'd0, 8'd0, 1'b0, 40'sh8000000000);
        send_item(1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0);
        send_item(1'b0, 8'd255, 8'd255, 8'd255, 1'b0, '0);
        send_item(1'b0, 8'd0, 8'd255, 8'd0, 1'b0, '0);
        send_item(1'b0, 8'd1, 8'd0, 8'd0, 1'b0, '0);
        send_item(1'b0, 8'd0, 8'd0, 8'd255, 1'b0, '0);
        send_item(1'b0, 8'd128, 8'd64, 8'd32, 1'b0, '0);
        send_item(1'b0, 8'd255, 8'd0, 8'd0, 1'b0, '0);
        send_item(1'b0, 8'd200, 8'd1, 8'd1, 1'b1, '0);
        // A negative preset at the lower limit, then another frame of the same size.
        send_preset(40'sh8000000000);
        send_frame(1'b0);
        wait_drained();

        // Tenths above ten saturate, and inner beyond outer gives empty walks.
        write_reg(rnaf_pkg::REG_INNER_TENTHS, 11'd15);
        write_reg(rnaf_pkg::REG_OUTER_TENTHS, 11'd15);
        send_frame(1'b0);
        wait_drained();
        write_reg(rnaf_pkg::REG_INNER_TENTHS, 11'd7);
        write_reg(rnaf_pkg::REG_OUTER_TENTHS, 11'd2);
        send_frame(1'b0);
        wait_drained();

        // Zero width makes every pixel off the frame; zero radius gives no result.
        write_geometry(1023, 1023, 1023, 0, 10, 0, 4);
        send_frame(1'b0);
        wait_drained();
        write_reg(rnaf_pkg::REG_RADIUS, 11'd0);
        write_reg(rnaf_pkg::REG_FRAME_WIDTH, 11'd2);
        send_frame(1'b0);
        wait_drained();

        // Width and height beyond their maxima saturate; the other dimension is zero.
        burst_mode = 1'b1;
        write_geometry(512, 0, 1023, 0, 10, 2047, 0);
        send_frame(1'b0);
        wait_drained();
        write_geometry(0, 300, 600, 3, 9, 0, 1023);
        send_frame(1'b0);
        wait_drained();
        burst_mode = 1'b0;

        // Random part: small frames and radii keep the search short.
        while (items_sent < 600)
        begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 10);
            write_geometry($urandom_range(0, w + 1), $urandom_range(0, h + 1),
                           $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 6),
                           $urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                     : $urandom_range(0, 4),
                           $urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                                                     : $urandom_range(5, 10),
                           w, h);
            if ($urandom_range(0, 1) == 0)
                write_reg(rnaf_pkg::REG_CENTER_X, 11'($urandom));
            burst_mode = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(1, 3))
            begin
                if ($urandom_range(0, 2) == 0)
                    send_preset(rand_reading());
                send_frame(1'b1);
            end
            wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rnaf_pkg.sv
hw/rtl/rnaf_if.sv
hw/rtl/rnaf_ram.sv
hw/rtl/rnaf_angle_rom.sv
hw/rtl/rnaf_ratio_div.sv
hw/rtl/radial_needle_angle_finder.sv
verif/radial_needle_angle_finder_tb.sv
